@@ hw/rtl/pool_free_list_allocator_core_defines.svh @@
// Assertion macros shared by the allocator checker
`ifndef POOL_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define POOL_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define PFLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pfla_pkg.sv @@
// Package: types, codes and field widths of the pool allocator
`timescale 1ns / 1ps
`default_nettype none

package pfla_pkg;

  localparam int unsigned POOL_SIZE_DEFAULT = 256;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_NOT_ACTIVE = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted_index;
    logic [LEN_W-1:0]  active_length;
    logic [LEN_W-1:0]  idle_length;
  } rsp_t;

  // datapath step issued by the controller each cycle
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_INIT,
    STEP_LOAD,
    STEP_LOOK,
    STEP_FIX_A,
    STEP_FIX_B,
    STEP_FIX_C
  } step_e;

  typedef struct packed {
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic go;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfla_dp.sv @@
// Datapath: link memories, list heads, length counters and result registers
`timescale 1ns / 1ps
`default_nettype none

module pfla_dp #(
  parameter int unsigned POOL_SIZE = pfla_pkg::POOL_SIZE_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfla_pkg::cmd_t  cmd_i,
  input  pfla_pkg::req_t  req_i,
  output pfla_pkg::stat_t stat_o,
  output pfla_pkg::rsp_t  rsp_o
);
  import pfla_pkg::*;

  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned LW = $clog2(POOL_SIZE + 1);
  localparam logic [LW-1:0] NONE = LW'(POOL_SIZE);
  localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

  logic [LW-1:0] next_mem [POOL_SIZE];
  logic [LW-1:0] prev_mem [POOL_SIZE];
  logic          used_mem [POOL_SIZE];

  logic [IW-1:0] init_cnt_q;
  logic          alloc_q, free_q, in_range_q;
  logic [IW-1:0] x_q;
  logic [LW-1:0] nxt_q, prv_q;
  logic          used_q;
  logic [LW-1:0] ah_q, ih_q;
  logic [LW-1:0] act_q, idl_q;
  status_e       status_q;
  logic [IDX_W-1:0] granted_q;

  // request decode at accept
  logic [IW+IDX_W-1:0] idx_wide;
  logic [IW-1:0]       rd_addr;
  logic                ld_alloc, ld_free, ld_in_range;

  assign idx_wide    = {{IW{1'b0}}, req_i.entry_index};
  assign ld_alloc    = (req_i.mode == MODE_ALLOC);
  assign ld_free     = (req_i.mode == MODE_FREE);
  assign ld_in_range = (32'(req_i.entry_index) < 32'(POOL_SIZE));

  always_comb begin
    rd_addr = '0;
    if (ld_alloc) begin
      if (ih_q != NONE) rd_addr = ih_q[IW-1:0];
    end else if (ld_in_range) begin
      rd_addr = idx_wide[IW-1:0];
    end
  end

  // write ports
  logic          nw_en, pw_en, uw_en;
  logic [IW-1:0] nw_addr, pw_addr, uw_addr;
  logic [LW-1:0] nw_data, pw_data;
  logic          uw_data;

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = x_q;
    nw_data = NONE;
    pw_en   = 1'b0;
    pw_addr = x_q;
    pw_data = NONE;
    uw_en   = 1'b0;
    uw_addr = x_q;
    uw_data = 1'b0;
    unique case (cmd_i.step)
      STEP_INIT: begin
        nw_en   = 1'b1;
        nw_addr = init_cnt_q;
        nw_data = LW'(init_cnt_q) + LW'(1);
        pw_en   = 1'b1;
        pw_addr = init_cnt_q;
        pw_data = (init_cnt_q == '0) ? NONE : LW'(init_cnt_q) - LW'(1);
        uw_en   = 1'b1;
        uw_addr = init_cnt_q;
      end
      STEP_FIX_A: begin
        // target entry gets its new links and flag
        nw_en   = 1'b1;
        nw_data = alloc_q ? ah_q : ih_q;
        pw_en   = 1'b1;
        uw_en   = 1'b1;
        uw_data = alloc_q;
      end
      STEP_FIX_B: begin
        if (alloc_q) begin
          pw_en   = (nxt_q != NONE);
          pw_addr = nxt_q[IW-1:0];
          pw_data = NONE;
        end else begin
          // bridge the neighbors around the freed entry
          nw_en   = (prv_q != NONE);
          nw_addr = prv_q[IW-1:0];
          nw_data = nxt_q;
          pw_en   = (nxt_q != NONE);
          pw_addr = nxt_q[IW-1:0];
          pw_data = prv_q;
        end
      end
      STEP_FIX_C: begin
        // old head of the destination list points back at the entry
        if (alloc_q) begin
          pw_en   = (ah_q != NONE);
          pw_addr = ah_q[IW-1:0];
        end else begin
          pw_en   = (ih_q != NONE);
          pw_addr = ih_q[IW-1:0];
        end
        pw_data = LW'(x_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (cmd_i.step == STEP_LOAD) nxt_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    if (cmd_i.step == STEP_LOAD) prv_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (uw_en) used_mem[uw_addr] <= uw_data;
    if (cmd_i.step == STEP_LOAD) used_q <= used_mem[rd_addr];
  end

  // decision after the link read
  logic    empty, go;
  status_e status_d;
  logic [IW+IDX_W-1:0] x_wide;

  assign empty  = (ih_q == NONE);
  assign x_wide = {{IDX_W{1'b0}}, x_q};

  always_comb begin
    go       = 1'b0;
    status_d = STAT_OK;
    if (alloc_q) begin
      go = !empty;
      if (empty) status_d = STAT_EMPTY;
    end else if (free_q) begin
      go = in_range_q && used_q;
      if (!go) status_d = STAT_NOT_ACTIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
      alloc_q    <= 1'b0;
      free_q     <= 1'b0;
      in_range_q <= 1'b0;
      x_q        <= '0;
      ah_q       <= NONE;
      ih_q       <= '0;
      act_q      <= '0;
      idl_q      <= NONE;
      status_q   <= STAT_OK;
      granted_q  <= '0;
    end else begin
      unique case (cmd_i.step)
        STEP_INIT: init_cnt_q <= init_cnt_q + IW'(1);
        STEP_LOAD: begin
          alloc_q    <= ld_alloc;
          free_q     <= ld_free;
          in_range_q <= ld_in_range;
          x_q        <= rd_addr;
        end
        STEP_LOOK: begin
          status_q  <= status_d;
          granted_q <= (alloc_q && go) ? x_wide[IDX_W-1:0] : '0;
        end
        STEP_FIX_C: begin
          if (alloc_q) begin
            ih_q  <= nxt_q;
            ah_q  <= LW'(x_q);
            idl_q <= idl_q - LW'(1);
            act_q <= act_q + LW'(1);
          end else begin
            if (ah_q == LW'(x_q)) ah_q <= nxt_q;
            ih_q  <= LW'(x_q);
            act_q <= act_q - LW'(1);
            idl_q <= idl_q + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  logic [LW+LEN_W-1:0] act_wide, idl_wide;
  assign act_wide = {{LEN_W{1'b0}}, act_q};
  assign idl_wide = {{LEN_W{1'b0}}, idl_q};

  assign stat_o.init_last = (init_cnt_q == LAST);
  assign stat_o.go        = go;

  assign rsp_o.status        = status_q;
  assign rsp_o.granted_index = granted_q;
  assign rsp_o.active_length = act_wide[LEN_W-1:0];
  assign rsp_o.idle_length   = idl_wide[LEN_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/pfla_ctrl.sv @@
// Controller: sequences init sweep, link read and link update steps
`timescale 1ns / 1ps
`default_nettype none

module pfla_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pfla_pkg::stat_t stat_i,
  output pfla_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import pfla_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_FIX_A,
    ST_FIX_B,
    ST_FIX_C,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  step_e  step;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    step    = STEP_IDLE;
    unique case (state_q)
      ST_INIT: begin
        step = STEP_INIT;
        if (stat_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE, ST_DONE: begin
        if (start_i) begin
          step    = STEP_LOAD;
          state_d = ST_LOOK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOK: begin
        step = STEP_LOOK;
        if (stat_i.go) begin
          state_d = ST_FIX_A;
        end else begin
          state_d = ST_DONE;
          done_d  = 1'b1;
        end
      end
      ST_FIX_A: begin
        step    = STEP_FIX_A;
        state_d = ST_FIX_B;
      end
      ST_FIX_B: begin
        step    = STEP_FIX_B;
        state_d = ST_FIX_C;
      end
      ST_FIX_C: begin
        step    = STEP_FIX_C;
        state_d = ST_DONE;
        done_d  = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.step = step;
  assign busy_o     = !((state_q == ST_IDLE) || (state_q == ST_DONE));
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ hw/rtl/pool_free_list_allocator_core.sv @@
// Top level of the fixed pool allocator with idle and active linked lists
//
// Usage:
//   Request channel: drive req_i and raise start; the item is taken at the
//   rising edge where start is high and busy is low. req_i.mode selects
//   allocate, free or query (the spare code acts as a query).
//   Result channel: done_o is high for exactly one cycle with rsp_o valid.
//   There is no back pressure; the receiver must capture rsp_o on done_o.
// Sequence:
//   A list-changing allocate or free runs accept with link read, decision,
//   three link update steps and result; done_o is registered from the last
//   update step and the next item is taken in the done_o cycle. Query,
//   empty-pool allocate and rejected free skip the updates, so done_o is
//   registered from the decision step. The updates are split into three by
//   the one prev-link write port, which an update hits up to three times.
// Reset:
//   After rst_ni rises the block sweeps all POOL_SIZE entries, one a cycle,
//   to link them onto the idle list in index order; busy stays high for the
//   whole sweep.
`timescale 1ns / 1ps
`default_nettype none

module pool_free_list_allocator_core #(
  parameter int unsigned POOL_SIZE = pfla_pkg::POOL_SIZE_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pfla_pkg::req_t req_i,
  output logic           done_o,
  output pfla_pkg::rsp_t rsp_o
);
  import pfla_pkg::*;

  // controller <-> datapath
  cmd_t  cmd;
  stat_t stat;

  pfla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // link memories, heads and counters; result held until the next item
  pfla_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pfla_checker.sv @@
// Port-level checker for the allocator and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "pool_free_list_allocator_core_defines.svh"

module pfla_checker #(
  parameter int unsigned POOL_SIZE = pfla_pkg::POOL_SIZE_DEFAULT
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire pfla_pkg::req_t req_i,
  input wire logic           done_o,
  input wire pfla_pkg::rsp_t rsp_o
);
  import pfla_pkg::*;

  `PFLA_ASSERT_NXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `PFLA_ASSERT_NXT(a_no_early_done, start && !busy, !done_o, "result in cycle after accept")
  `PFLA_ASSERT_IMP(a_status_code, done_o, rsp_o.status == STAT_OK || rsp_o.status == STAT_EMPTY || rsp_o.status == STAT_NOT_ACTIVE, "undefined status code")
  `PFLA_ASSERT_IMP(a_len_sum, done_o, 9'(rsp_o.active_length + rsp_o.idle_length) == 9'(POOL_SIZE), "list lengths do not add to pool size")
  `PFLA_ASSERT_IMP(a_grant_zero, done_o && rsp_o.status != STAT_OK, rsp_o.granted_index == '0, "nonzero grant on failed item")

endmodule

bind pool_free_list_allocator_core pfla_checker #(
  .POOL_SIZE (POOL_SIZE)
) u_pfla_checker (.*);

`default_nettype wire
